FILE: rtl/wheel_and_servo_pwm_core_macros.svh
// assertion macros for the wheel and servo pwm core
// expects aclk and aresetn in the scope of the module that uses them
`ifndef WHEEL_AND_SERVO_PWM_CORE_MACROS_SVH
`define WHEEL_AND_SERVO_PWM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define WSP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("wspwm assertion failed");
`define WSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wspwm assertion failed");
`else
`define WSP_ASSERT_ALWAYS(label, cond)
`define WSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/wspwm_pkg.sv
// shared constants, register codes and types for the wheel and servo pwm core
// no dependencies
package wspwm_pkg;

    localparam int unsigned SPEED_W    = 7;
    localparam int unsigned DUTY_W     = 7;
    localparam int unsigned DIV_W      = 7;
    localparam int unsigned COUNT_W    = 12;
    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned FRAME_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [DIV_W-1:0]   WHEEL_DIVIDE   = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_INCREMENT = 7'd10;
    localparam logic [DUTY_W-1:0]  DUTY_LIMIT     = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_MAX_SEEN  = 7'd110;
    localparam logic [COUNT_W-1:0] SERVO_FRAME    = 12'd2000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 12'd4095;
    localparam logic [PULSE_W-1:0] PULSE_RESET    = 12'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_SPEED         = 3'd0,
        CFG_RIGHT_SPEED        = 3'd1,
        CFG_WHEEL_ENABLES      = 3'd2,
        CFG_WHEEL_DIRECTIONS   = 3'd3,
        CFG_TOP_PULSE_WIDTH    = 3'd4,
        CFG_BOTTOM_PULSE_WIDTH = 3'd5,
        CFG_SERVO_ENABLES      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic pin;
        logic wrap;
    } servo_status_t;

endpackage

FILE: rtl/wheel_and_servo_pwm_core.sv
// Wheel and servo PWM core. Each request carries one timer tick; the core answers every
// request with one result holding the four wheel pins, the two servo pins and the frame
// total as they stand after that tick (a request with tick low changes nothing and reports
// the current state). Requests are registered on entry and applied to the counters as they
// move into the result register, so one request per cycle is sustained while m_ready keeps
// the result register from stalling; the divider, duty step and servo counters update as
// the request enters it. Configuration writes take effect on the next clock and belong to
// idle periods.
// depends on wspwm_pkg, wspwm_servo and wheel_and_servo_pwm_core_macros.svh
`include "wheel_and_servo_pwm_core_macros.svh"

module wheel_and_servo_pwm_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wspwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wspwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_tick,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_left_cw_pin,
    output logic                                m_left_ccw_pin,
    output logic                                m_right_ccw_pin,
    output logic                                m_right_cw_pin,
    output logic                                m_top_servo_pin,
    output logic                                m_bottom_servo_pin,
    output logic [wspwm_pkg::FRAME_W-1:0]       m_frame_total
);

    // configuration
    logic [wspwm_pkg::SPEED_W-1:0] left_speed_reg;
    logic [wspwm_pkg::SPEED_W-1:0] right_speed_reg;
    logic [1:0]                    wheel_enables_reg;
    logic [1:0]                    wheel_directions_reg;
    logic [wspwm_pkg::PULSE_W-1:0] top_pulse_width_reg;
    logic [wspwm_pkg::PULSE_W-1:0] bottom_pulse_width_reg;
    logic [1:0]                    servo_enables_reg;

    // request and result stages
    logic in_valid_reg;
    logic in_tick_reg;
    logic out_valid_reg;
    logic advance;
    logic tick_go;

    // wheel state
    logic [wspwm_pkg::DIV_W-1:0]  divider_reg;
    logic [wspwm_pkg::DIV_W-1:0]  divider_next;
    logic [wspwm_pkg::DUTY_W-1:0] duty_reg;
    logic [wspwm_pkg::DUTY_W-1:0] duty_next;
    logic [3:0]                   wheel_pins_reg;
    logic [3:0]                   wheel_pins_next;
    logic [wspwm_pkg::DIV_W-1:0]  div_inc;
    logic [wspwm_pkg::DUTY_W-1:0] duty_clr;
    logic [wspwm_pkg::DUTY_W-1:0] duty_inc;
    logic                         wheel_strobe;
    logic                         left_on;
    logic                         right_on;
    logic [3:0]                   wheel_pins_calc;

    // servo state
    logic [wspwm_pkg::FRAME_W-1:0] frame_reg;
    logic [wspwm_pkg::FRAME_W-1:0] frame_next;
    wspwm_pkg::servo_status_t      top_status;
    wspwm_pkg::servo_status_t      bottom_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_speed_reg         <= '0;
            right_speed_reg        <= '0;
            wheel_enables_reg      <= '0;
            wheel_directions_reg   <= '0;
            top_pulse_width_reg    <= wspwm_pkg::PULSE_RESET;
            bottom_pulse_width_reg <= wspwm_pkg::PULSE_RESET;
            servo_enables_reg      <= '0;
        end else if (cfg_we) begin
            unique case (wspwm_pkg::cfg_reg_t'(cfg_index))
                wspwm_pkg::CFG_LEFT_SPEED: begin
                    left_speed_reg <= cfg_wdata[wspwm_pkg::SPEED_W-1:0];
                end
                wspwm_pkg::CFG_RIGHT_SPEED: begin
                    right_speed_reg <= cfg_wdata[wspwm_pkg::SPEED_W-1:0];
                end
                wspwm_pkg::CFG_WHEEL_ENABLES: begin
                    wheel_enables_reg <= cfg_wdata[1:0];
                end
                wspwm_pkg::CFG_WHEEL_DIRECTIONS: begin
                    wheel_directions_reg <= cfg_wdata[1:0];
                end
                wspwm_pkg::CFG_TOP_PULSE_WIDTH: begin
                    top_pulse_width_reg <= cfg_wdata[wspwm_pkg::PULSE_W-1:0];
                end
                wspwm_pkg::CFG_BOTTOM_PULSE_WIDTH: begin
                    bottom_pulse_width_reg <= cfg_wdata[wspwm_pkg::PULSE_W-1:0];
                end
                wspwm_pkg::CFG_SERVO_ENABLES: begin
                    servo_enables_reg <= cfg_wdata[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a request moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign tick_go = advance && in_tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_tick_reg <= s_tick;
        end
    end

    // wheel pwm
    assign div_inc      = divider_reg + 1'b1;
    assign duty_clr     = (duty_reg > wspwm_pkg::DUTY_LIMIT) ? '0 : duty_reg;
    assign duty_inc     = duty_clr + wspwm_pkg::DUTY_INCREMENT;
    assign wheel_strobe = (div_inc == wspwm_pkg::WHEEL_DIVIDE);
    assign left_on      = wheel_enables_reg[0] && (duty_inc <= left_speed_reg);
    assign right_on     = wheel_enables_reg[1] && (duty_inc <= right_speed_reg);

    always_comb begin
        wheel_pins_calc[0] = left_on && !wheel_directions_reg[0];
        wheel_pins_calc[1] = left_on && wheel_directions_reg[0];
        wheel_pins_calc[2] = right_on && wheel_directions_reg[1];
        wheel_pins_calc[3] = right_on && !wheel_directions_reg[1];
    end

    always_comb begin
        divider_next    = divider_reg;
        duty_next       = duty_reg;
        wheel_pins_next = wheel_pins_reg;
        if (tick_go) begin
            if (wheel_strobe) begin
                divider_next    = '0;
                duty_next       = duty_inc;
                wheel_pins_next = wheel_pins_calc;
            end else begin
                divider_next = div_inc;
                duty_next    = duty_clr;
            end
        end
    end

    // servos
    wspwm_servo u_top_servo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_go     (tick_go),
        .enable      (servo_enables_reg[0]),
        .pulse_width (top_pulse_width_reg),
        .status      (top_status)
    );

    wspwm_servo u_bottom_servo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_go     (tick_go),
        .enable      (servo_enables_reg[1]),
        .pulse_width (bottom_pulse_width_reg),
        .status      (bottom_status)
    );

    assign frame_next = frame_reg
                      + {{(wspwm_pkg::FRAME_W-1){1'b0}}, top_status.wrap}
                      + {{(wspwm_pkg::FRAME_W-1){1'b0}}, bottom_status.wrap};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg    <= '0;
            duty_reg       <= '0;
            wheel_pins_reg <= '0;
            frame_reg      <= '0;
        end else begin
            divider_reg    <= divider_next;
            duty_reg       <= duty_next;
            wheel_pins_reg <= wheel_pins_next;
            frame_reg      <= frame_next;
        end
    end

    // state only changes when a request enters the result register, so it is the result
    assign m_valid            = out_valid_reg;
    assign m_left_cw_pin      = wheel_pins_reg[0];
    assign m_left_ccw_pin     = wheel_pins_reg[1];
    assign m_right_ccw_pin    = wheel_pins_reg[2];
    assign m_right_cw_pin     = wheel_pins_reg[3];
    assign m_top_servo_pin    = top_status.pin;
    assign m_bottom_servo_pin = bottom_status.pin;
    assign m_frame_total      = frame_reg;

    `WSP_ASSERT_ALWAYS(a_duty_range, duty_reg <= wspwm_pkg::DUTY_MAX_SEEN)
    `WSP_ASSERT_ALWAYS(a_divider_range, divider_reg < wspwm_pkg::WHEEL_DIVIDE)
    `WSP_ASSERT_ALWAYS(a_bridge_exclusive, !(&wheel_pins_reg[1:0]) && !(&wheel_pins_reg[3:2]))
    `WSP_ASSERT_NEXT(a_frame_hold, aresetn && !advance, $stable(frame_reg))
    `WSP_ASSERT_NEXT(a_wheel_hold, aresetn && !(tick_go && wheel_strobe), $stable(wheel_pins_reg))

endmodule

FILE: rtl/wspwm_servo.sv
// one servo channel: frame counter, pulse compare and pin state
// depends on wspwm_pkg
module wspwm_servo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                tick_go,
    input  logic                                enable,
    input  logic [wspwm_pkg::PULSE_W-1:0]       pulse_width,
    output wspwm_pkg::servo_status_t            status
);

    logic [wspwm_pkg::COUNT_W-1:0] count_reg;
    logic [wspwm_pkg::COUNT_W-1:0] count_next;
    logic [wspwm_pkg::COUNT_W-1:0] count_adv;
    logic                          pin_reg;
    logic                          pin_next;
    logic                          frame_hit;

    // count saturates while the servo is off
    assign count_adv = (count_reg == wspwm_pkg::COUNT_MAX) ? wspwm_pkg::COUNT_MAX
                                                           : count_reg + 1'b1;
    assign frame_hit = (count_adv >= wspwm_pkg::SERVO_FRAME);

    always_comb begin
        count_next = count_reg;
        pin_next   = pin_reg;
        if (tick_go) begin
            count_next = count_adv;
            if (enable) begin
                pin_next = (count_adv < pulse_width);
                if (frame_hit) begin
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pin_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            pin_reg   <= pin_next;
        end
    end

    assign status.pin  = pin_reg;
    assign status.wrap = tick_go && enable && frame_hit;

endmodule
